@@ rtl/scfac_pkg.sv @@
// ----------------------------------------------------------------------------
// scfac_pkg
// Shared types, character codes and letter classifiers for the scan format
// assignment counter.
// ----------------------------------------------------------------------------
package scfac_pkg;

    // Width of the internal conversion counter; it saturates at all ones.
    localparam int COUNT_BITS = 12;
    // Width of the count field on the result channel.
    localparam int ASSIGN_COUNT_W = 12;

    localparam logic [7:0] CH_PERCENT = 8'h25;
    localparam logic [7:0] CH_LBRACKET = 8'h5B;
    localparam logic [7:0] CH_RBRACKET = 8'h5D;
    localparam logic [7:0] CH_CARET = 8'h5E;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;

    typedef enum logic [2:0] {
        PH_TEXT    = 3'd0,
        PH_PCT     = 3'd1,
        PH_LEN1    = 3'd2,
        PH_LEN2    = 3'd3,
        PH_SETOPEN = 3'd4,
        PH_CARET   = 3'd5,
        PH_BODY    = 3'd6
    } phase_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic                  ended;
    } scfac_result_t;

    function automatic logic is_conv_letter(input logic [7:0] c);
        case (c) inside
            "d", "i", "o", "u", "x", "a", "e", "f", "g", "c", "s", "p",
            "A", "E", "F", "G", "X": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_len_first(input logic [7:0] c);
        case (c) inside
            "h", "l", "j", "z", "t", "L": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

    function automatic logic is_len_second(input logic [7:0] c);
        case (c) inside
            "h", "l": return 1'b1;
            default: return 1'b0;
        endcase
    endfunction

endpackage

@@ rtl/scan_format_assignment_counter.sv @@
// ----------------------------------------------------------------------------
// scan_format_assignment_counter
// Counts the assigning conversions of a scanf-style format string.
// ----------------------------------------------------------------------------
// Usage:
//   The input channel (s_*) takes one format byte per transaction, with
//   s_last_char marking the final byte of a string. One result transaction
//   leaves on the m_* channel for each string: the number of assigning
//   conversions (saturating at all ones) and a flag set when the string ended
//   inside a conversion or an open scanset. Bytes that are not last produce
//   no result.
//   Throughput is one byte per cycle while no last byte waits for the output
//   register. A byte is held in an input register and parsed in the next
//   cycle; for a last byte the result then passes into the output register,
//   unless the output is still holding an earlier result.
//   Reset clears the parse state, the count and both valid flags; the block
//   takes bytes in the first cycle after reset.
//   When the receiver stalls, bytes that are not last keep flowing; a last
//   byte waits in the input register until the output register is free,
//   and s_ready drops only then.
// ----------------------------------------------------------------------------
module scan_format_assignment_counter
    import scfac_pkg::*;
(
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_valid,
    output logic                      s_ready,
    input  logic [7:0]                s_format_char,
    input  logic                      s_last_char,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [ASSIGN_COUNT_W-1:0] m_assignment_count,
    output logic                      m_ended_inside_conversion
);

    logic                      in_valid_reg;
    logic [7:0]                in_char_reg;
    logic                      in_last_reg;
    logic                      out_valid_reg;
    logic [ASSIGN_COUNT_W-1:0] out_count_reg;
    logic                      out_ended_reg;
    logic                      advance;
    scfac_result_t             result;

    // a last byte advances only if the output register can take its result
    assign advance = in_valid_reg && (!in_last_reg || !out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    scfac_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (advance),
        .format_char (in_char_reg),
        .last_char   (in_last_reg),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance && in_last_reg) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_format_char;
            in_last_reg <= s_last_char;
        end
        if (advance && in_last_reg) begin
            out_count_reg <= ASSIGN_COUNT_W'(result.count);
            out_ended_reg <= result.ended;
        end
    end

    assign m_valid                   = out_valid_reg;
    assign m_assignment_count        = out_count_reg;
    assign m_ended_inside_conversion = out_ended_reg;

endmodule

@@ rtl/scfac_parser.sv @@
// ----------------------------------------------------------------------------
// scfac_parser
// Parse phase and saturating counter; advances one character per step and
// presents the string result on the step that carries the last character.
// ----------------------------------------------------------------------------
module scfac_parser
    import scfac_pkg::*;
(
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          step,
    input  logic [7:0]    format_char,
    input  logic          last_char,
    output scfac_result_t result
);

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    phase_t                phase_reg, phase_next, phase_adv;
    logic [COUNT_BITS-1:0] count_reg, count_next, count_adv;
    logic                  bump;

    always_comb begin
        phase_adv = phase_reg;
        bump      = 1'b0;
        case (phase_reg)
            PH_PCT: begin
                if (format_char >= CH_DIGIT_0 && format_char <= CH_DIGIT_9) begin
                    phase_adv = PH_PCT;
                end else if (is_len_first(format_char)) begin
                    phase_adv = PH_LEN1;
                end else if (format_char == CH_LBRACKET) begin
                    phase_adv = PH_SETOPEN;
                end else begin
                    bump      = is_conv_letter(format_char);
                    phase_adv = PH_TEXT;
                end
            end
            PH_LEN1: begin
                if (is_len_second(format_char)) begin
                    phase_adv = PH_LEN2;
                end else begin
                    bump      = is_conv_letter(format_char);
                    phase_adv = PH_TEXT;
                end
            end
            PH_LEN2: begin
                bump      = is_conv_letter(format_char);
                phase_adv = PH_TEXT;
            end
            PH_SETOPEN: begin
                phase_adv = (format_char == CH_CARET) ? PH_CARET : PH_BODY;
            end
            PH_CARET: begin
                // the byte after "[^" is always a set member
                phase_adv = PH_BODY;
            end
            PH_BODY: begin
                if (format_char == CH_RBRACKET) begin
                    bump      = 1'b1;
                    phase_adv = PH_TEXT;
                end
            end
            default: begin
                phase_adv = (format_char == CH_PERCENT) ? PH_PCT : PH_TEXT;
            end
        endcase

        count_adv = (bump && count_reg != COUNT_MAX) ? count_reg + COUNT_BITS'(1)
                                                     : count_reg;

        result.count = count_adv;
        result.ended = (phase_adv != PH_TEXT);

        phase_next = phase_reg;
        count_next = count_reg;
        if (step) begin
            if (last_char) begin
                // start over for the next string
                phase_next = PH_TEXT;
                count_next = '0;
            end else begin
                phase_next = phase_adv;
                count_next = count_adv;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_TEXT;
            count_reg <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
        end
    end

endmodule

@@ rtl/scfac_checker.sv @@
// ----------------------------------------------------------------------------
// scfac_checker
// Port-level checks for the scan format assignment counter.
// ----------------------------------------------------------------------------
module scfac_checker
    import scfac_pkg::*;
(
    input logic                      aclk,
    input logic                      aresetn,
    input logic                      s_valid,
    input logic                      s_ready,
    input logic                      m_valid,
    input logic                      m_ready,
    input logic [ASSIGN_COUNT_W-1:0] m_assignment_count,
    input logic                      m_ended_inside_conversion
);

    // reset empties the output register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // input backpressure only comes from a stalled, full output
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready))
        else $error("input stalled while output free");

    // a held result keeps its payload
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_assignment_count)
                                   && $stable(m_ended_inside_conversion)))
        else $error("stalled result changed");

    // a result needs some input first; this check cannot fail, as its last term repeats the antecedent's !s_valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_valid && !s_valid && s_ready) |=> ##1 (!m_valid || $past(s_valid, 1)
                                                   || $past(s_valid, 2) == 1'b0))
        else $error("result appeared without input");

endmodule

bind scan_format_assignment_counter scfac_checker u_scfac_checker (
    .aclk                      (aclk),
    .aresetn                   (aresetn),
    .s_valid                   (s_valid),
    .s_ready                   (s_ready),
    .m_valid                   (m_valid),
    .m_ready                   (m_ready),
    .m_assignment_count        (m_assignment_count),
    .m_ended_inside_conversion (m_ended_inside_conversion)
);
